// File: rtl/rzm_pkg.sv
// rotozoom texel mapper package: register map, config and trig types, rom builder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rzm_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_SPRITE_X      = 3'd0;
    localparam logic [2:0] REG_SPRITE_Y      = 3'd1;
    localparam logic [2:0] REG_SPRITE_ANGLE  = 3'd2;
    localparam logic [2:0] REG_SPRITE_ZOOM   = 3'd3;
    localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd5;

    // reset values of the registers
    localparam logic [15:0] ZOOM_UNITY   = 16'd256;
    localparam logic [7:0]  WIDTH_RESET  = 8'd32;
    localparam logic [7:0]  HEIGHT_RESET = 8'd16;

    // zoom divider: 17-bit dividend, one quotient bit a cycle
    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = 5;

    // pi in q40, used to build the quarter cosine table
    localparam logic [63:0] PI_Q40 = 64'd3454217652358;

    typedef struct packed {
        logic [23:0] sprite_x;
        logic [23:0] sprite_y;
        logic [9:0]  sprite_angle;
        logic [15:0] sprite_zoom;
        logic [7:0]  sprite_width;
        logic [7:0]  sprite_height;
    } rzm_cfg_t;

    typedef struct packed {
        logic [15:0] cs;
        logic [15:0] sn;
    } rzm_trig_t;

    typedef enum logic [2:0] {
        TRIG_IDLE,
        TRIG_LOAD,
        TRIG_REDUCE,
        TRIG_LOOKUP,
        TRIG_SCALE,
        TRIG_DIVIDE
    } trig_state_t;

    // one series term divided by its factorial step, divisors are literals
    function automatic logic [63:0] series_div(input logic [63:0] t, input int k,
                                               input logic use_sin);
        logic [63:0] r;
        r = t;
        if (use_sin) begin
            unique case (k)
                1:  r = t / 64'd6;
                2:  r = t / 64'd20;
                3:  r = t / 64'd42;
                4:  r = t / 64'd72;
                5:  r = t / 64'd110;
                6:  r = t / 64'd156;
                7:  r = t / 64'd210;
                8:  r = t / 64'd272;
                9:  r = t / 64'd342;
                10: r = t / 64'd420;
                11: r = t / 64'd506;
                12: r = t / 64'd600;
                default: r = t;
            endcase
        end
        else begin
            unique case (k)
                1:  r = t / 64'd2;
                2:  r = t / 64'd12;
                3:  r = t / 64'd30;
                4:  r = t / 64'd56;
                5:  r = t / 64'd90;
                6:  r = t / 64'd132;
                7:  r = t / 64'd182;
                8:  r = t / 64'd240;
                9:  r = t / 64'd306;
                10: r = t / 64'd380;
                11: r = t / 64'd462;
                12: r = t / 64'd552;
                default: r = t;
            endcase
        end
        return r;
    endfunction

    // floor(256*cos) of one table entry, q31 taylor series, elaboration only
    function automatic logic [8:0] quarter_entry(input logic is_zero, input logic is_end,
                                                 input logic use_sin, input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x2   = (x * x) >> 31;
        term = use_sin ? x : (64'd1 << 31);
        sum  = signed'(term);
        for (int k = 1; k <= 12; k++) begin
            term = series_div((term * x2) >> 31, k, use_sin);
            if ((k % 2) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        scaled = (unsigned'(sum) * 64'd256) >> 31;
        if (is_zero)
            return 9'd256;
        else if (is_end)
            return 9'd0;
        else
            return scaled[8:0];
    endfunction

endpackage

// File: rtl/rzm_cfg_regs.sv
// rotozoom texel mapper configuration registers behind the apb-style port
// depends on rzm_pkg
`timescale 1ns / 1ps

module rzm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rzm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rzm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rzm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output rzm_pkg::rzm_cfg_t              cfg,
    output logic                           cfg_write
);

    rzm_pkg::rzm_cfg_t cfg_reg;
    rzm_pkg::rzm_cfg_t cfg_next;
    logic [2:0]        reg_index;
    logic              wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel & penable & pwrite;
    assign cfg_write = wr_en;
    assign cfg       = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                rzm_pkg::REG_SPRITE_X:      cfg_next.sprite_x      = pwdata[23:0];
                rzm_pkg::REG_SPRITE_Y:      cfg_next.sprite_y      = pwdata[23:0];
                rzm_pkg::REG_SPRITE_ANGLE:  cfg_next.sprite_angle  = pwdata[9:0];
                rzm_pkg::REG_SPRITE_ZOOM:   cfg_next.sprite_zoom   = pwdata[15:0];
                rzm_pkg::REG_SPRITE_WIDTH:  cfg_next.sprite_width  = pwdata[7:0];
                rzm_pkg::REG_SPRITE_HEIGHT: cfg_next.sprite_height = pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_x      <= '0;
            cfg_reg.sprite_y      <= '0;
            cfg_reg.sprite_angle  <= '0;
            cfg_reg.sprite_zoom   <= rzm_pkg::ZOOM_UNITY;
            cfg_reg.sprite_width  <= rzm_pkg::WIDTH_RESET;
            cfg_reg.sprite_height <= rzm_pkg::HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_index)
            rzm_pkg::REG_SPRITE_X:      prdata = 32'(cfg_reg.sprite_x);
            rzm_pkg::REG_SPRITE_Y:      prdata = 32'(cfg_reg.sprite_y);
            rzm_pkg::REG_SPRITE_ANGLE:  prdata = 32'(cfg_reg.sprite_angle);
            rzm_pkg::REG_SPRITE_ZOOM:   prdata = 32'(cfg_reg.sprite_zoom);
            rzm_pkg::REG_SPRITE_WIDTH:  prdata = 32'(cfg_reg.sprite_width);
            rzm_pkg::REG_SPRITE_HEIGHT: prdata = 32'(cfg_reg.sprite_height);
            default:                    prdata = '0;
        endcase
    end

endmodule

// File: rtl/rzm_zoom_div.sv
// restoring divider for trig scaling, one quotient bit per cycle
// depends on rzm_pkg
`timescale 1ns / 1ps

module rzm_zoom_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rzm_pkg::DIV_W-1:0] dividend,
    input  logic [15:0]               divisor,
    output logic                      done,
    output logic [rzm_pkg::DIV_W-1:0] quotient
);

    localparam logic [rzm_pkg::DIV_CNT_W-1:0] LAST_STEP =
        rzm_pkg::DIV_CNT_W'(rzm_pkg::DIV_W - 1);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [rzm_pkg::DIV_CNT_W-1:0]     count_reg;
    logic [rzm_pkg::DIV_CNT_W-1:0]     count_next;
    logic [rzm_pkg::DIV_W-1:0]         quot_reg;
    logic [rzm_pkg::DIV_W-1:0]         quot_next;
    logic [15:0]                       rem_reg;
    logic [15:0]                       rem_next;
    logic [16:0]                       shifted;
    logic [16:0]                       trial;
    logic                              fits;

    assign done     = done_reg;
    assign quotient = quot_reg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted    = {rem_reg, quot_reg[rzm_pkg::DIV_W-1]};
        trial      = shifted - {1'b0, divisor};
        fits       = shifted >= {1'b0, divisor};
        busy_next  = busy_reg;
        done_next  = done_reg;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            count_next = '0;
            quot_next  = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? trial[15:0] : shifted[15:0];
            quot_next  = {quot_reg[rzm_pkg::DIV_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

endmodule

// File: rtl/rzm_trig_unit.sv
// rotozoom trig unit: quarter cosine table, angle folding and zoom scaling
// depends on rzm_pkg and rzm_zoom_div; recomputes after every register write
`timescale 1ns / 1ps

module rzm_trig_unit #(
    parameter int ANGLE_STEPS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  rzm_pkg::rzm_cfg_t  cfg,
    output logic               busy,
    output rzm_pkg::rzm_trig_t trig
);

    localparam int QUARTER   = ANGLE_STEPS / 4;
    localparam int HALF      = ANGLE_STEPS / 2;
    localparam int ROM_DEPTH = QUARTER + 1;
    localparam int IDX_W     = $clog2(ROM_DEPTH);
    localparam int RW        = ($clog2(ANGLE_STEPS + 1) > 11) ? $clog2(ANGLE_STEPS + 1) : 11;

    localparam logic [RW-1:0] STEPS_R   = RW'(ANGLE_STEPS);
    localparam logic [RW-1:0] HALF_R    = RW'(HALF);
    localparam logic [RW-1:0] QUARTER_R = RW'(QUARTER);

    // lane 0 is cosine, lane 1 is sine
    rzm_pkg::trig_state_t     state_reg;
    rzm_pkg::trig_state_t     state_next;
    rzm_pkg::rzm_trig_t       trig_reg;
    rzm_pkg::rzm_trig_t       trig_next;
    logic [RW-1:0]            ang_reg [2];
    logic [RW-1:0]            ang_next [2];
    logic [8:0]               mag_reg [2];
    logic [8:0]               mag_next [2];
    logic                     neg_reg [2];
    logic                     neg_next [2];
    logic [RW-1:0]            a_half [2];
    logic                     fold_neg [2];
    logic [IDX_W-1:0]         fold_idx [2];
    logic [8:0]               fold_mag [2];
    logic [15:0]              direct_val [2];
    logic [15:0]              div_val [2];
    logic [rzm_pkg::DIV_W-1:0] quot [2];
    logic                     div_done [2];
    logic                     div_start;
    logic [RW:0]              angle_ext;
    logic [RW:0]              sin_diff;
    logic [RW:0]              sin_diff_neg;
    logic [RW-1:0]            sin_abs;
    logic                     reduced;
    logic                     zoom_bypass;
    logic [8:0]               rom_table [ROM_DEPTH];

    // quarter cosine table, built at elaboration
    for (genvar gi = 0; gi < ROM_DEPTH; gi++)
    begin : g_rom
        localparam bit          USE_SIN = (2 * gi > QUARTER);
        localparam logic [63:0] J       = USE_SIN ? 64'(QUARTER - gi) : 64'(gi);
        localparam logic [63:0] X       = ((J * rzm_pkg::PI_Q40 * 64'd2) / ANGLE_STEPS) >> 9;
        localparam logic [8:0]  ENTRY   =
            rzm_pkg::quarter_entry(gi == 0, gi >= QUARTER, USE_SIN, X);
        assign rom_table[gi] = ENTRY;
    end

    // zoom dividers, one per lane
    for (genvar gl = 0; gl < 2; gl++)
    begin : g_div
        rzm_zoom_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend ({mag_reg[gl], 8'd0}),
            .divisor  (cfg.sprite_zoom),
            .done     (div_done[gl]),
            .quotient (quot[gl])
        );
    end

    assign busy = (state_reg != rzm_pkg::TRIG_IDLE);
    assign trig = trig_reg;

    // sine angle is the magnitude of angle minus a quarter turn
    always_comb
    begin
        angle_ext    = (RW + 1)'(cfg.sprite_angle);
        sin_diff     = angle_ext - (RW + 1)'(QUARTER);
        sin_diff_neg = (RW + 1)'(0) - sin_diff;
        sin_abs      = sin_diff[RW] ? sin_diff_neg[RW-1:0] : sin_diff[RW-1:0];
        zoom_bypass  = (cfg.sprite_zoom == rzm_pkg::ZOOM_UNITY) || (cfg.sprite_zoom == '0);
        reduced      = (ang_reg[0] < STEPS_R) && (ang_reg[1] < STEPS_R);
    end

    // symmetry folding into the quarter table, signed results per lane
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            a_half[i]     = (ang_reg[i] > HALF_R) ? (STEPS_R - ang_reg[i]) : ang_reg[i];
            fold_neg[i]   = a_half[i] > QUARTER_R;
            fold_idx[i]   = fold_neg[i] ? IDX_W'(HALF_R - a_half[i]) : IDX_W'(a_half[i]);
            fold_mag[i]   = rom_table[fold_idx[i]];
            direct_val[i] = neg_reg[i] ? (16'd0 - {7'd0, mag_reg[i]}) : {7'd0, mag_reg[i]};
            div_val[i]    = neg_reg[i] ? (16'd0 - quot[i][15:0]) : quot[i][15:0];
        end
    end

    // sequencer: load, reduce modulo a turn, look up, scale by zoom
    always_comb
    begin
        state_next = state_reg;
        trig_next  = trig_reg;
        div_start  = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            ang_next[i] = ang_reg[i];
            mag_next[i] = mag_reg[i];
            neg_next[i] = neg_reg[i];
        end
        unique case (state_reg)
            rzm_pkg::TRIG_IDLE: ;
            rzm_pkg::TRIG_LOAD:
            begin
                ang_next[0] = RW'(cfg.sprite_angle);
                ang_next[1] = sin_abs;
                state_next  = rzm_pkg::TRIG_REDUCE;
            end
            rzm_pkg::TRIG_REDUCE:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (ang_reg[i] >= STEPS_R)
                        ang_next[i] = ang_reg[i] - STEPS_R;
                end
                if (reduced)
                    state_next = rzm_pkg::TRIG_LOOKUP;
            end
            rzm_pkg::TRIG_LOOKUP:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    mag_next[i] = fold_mag[i];
                    neg_next[i] = fold_neg[i];
                end
                state_next = rzm_pkg::TRIG_SCALE;
            end
            rzm_pkg::TRIG_SCALE:
            begin
                if (zoom_bypass)
                begin
                    trig_next.cs = direct_val[0];
                    trig_next.sn = direct_val[1];
                    state_next   = rzm_pkg::TRIG_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = rzm_pkg::TRIG_DIVIDE;
                end
            end
            rzm_pkg::TRIG_DIVIDE:
            begin
                if (div_done[0] && div_done[1])
                begin
                    trig_next.cs = div_val[0];
                    trig_next.sn = div_val[1];
                    state_next   = rzm_pkg::TRIG_IDLE;
                end
            end
            default: state_next = rzm_pkg::TRIG_IDLE;
        endcase
        // any register write restarts the computation
        if (cfg_write)
            state_next = rzm_pkg::TRIG_LOAD;
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rzm_pkg::TRIG_IDLE;
            trig_reg  <= '{cs: rzm_pkg::ZOOM_UNITY, sn: 16'd0};
        end
        else
        begin
            state_reg <= state_next;
            trig_reg  <= trig_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            ang_reg[i] <= ang_next[i];
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= neg_next[i];
        end
    end

endmodule

// File: rtl/rzm_map_pipe.sv
// rotozoom mapping pipeline: offset, rotate products, bounds test, address
// depends on rzm_pkg; four register stages with valid bits and stall chain
`timescale 1ns / 1ps

module rzm_map_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  rzm_pkg::rzm_cfg_t  cfg,
    input  rzm_pkg::rzm_trig_t trig,
    input  logic               hold,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [9:0]         pixel_x,
    input  logic [9:0]         pixel_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [15:0]        texel_address
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        adv1, adv2, adv3, adv4;
    logic [15:0] ox_reg, oy_reg;
    logic [15:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic        hit3_reg;
    logic [7:0]  tx3_reg, ty3_reg;
    logic        hit4_reg;
    logic [15:0] addr4_reg;
    logic [15:0] ox_next, oy_next;
    logic [15:0] m_xc, m_ys, m_xs, m_yc;
    logic [15:0] u_val, v_val;
    logic        hit3_next;
    logic [15:0] addr_prod;
    logic [15:0] addr_next;

    // stall chain: a stage moves when it is empty or the next one moves
    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1 && !hold;

    assign out_valid     = v4_reg;
    assign hit           = hit4_reg;
    assign texel_address = addr4_reg;

    // stage 1: offsets from the sprite centre in whole pixels
    assign ox_next = {6'd0, pixel_x} - cfg.sprite_x[23:8];
    assign oy_next = {6'd0, pixel_y} - cfg.sprite_y[23:8];

    // stage 2: rotation products, low half only
    assign m_xc = ox_reg * trig.cs;
    assign m_ys = oy_reg * trig.sn;
    assign m_xs = ox_reg * trig.sn;
    assign m_yc = oy_reg * trig.cs;

    // stage 3: texel coordinates and bounds test
    always_comb
    begin
        u_val     = p_xc_reg - p_ys_reg + {1'b0, cfg.sprite_width, 7'd0};
        v_val     = p_xs_reg + p_yc_reg + {1'b0, cfg.sprite_height, 7'd0};
        hit3_next = !u_val[15] && !v_val[15]
                    && (u_val[15:8] < cfg.sprite_width)
                    && (v_val[15:8] < cfg.sprite_height)
                    && (cfg.sprite_zoom != '0);
    end

    // stage 4: linear texel address
    assign addr_prod = {8'd0, cfg.sprite_width} * {8'd0, ty3_reg};
    assign addr_next = hit3_reg ? (addr_prod + {8'd0, tx3_reg}) : 16'd0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid && in_ready;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
        if (adv2)
        begin
            p_xc_reg <= m_xc;
            p_ys_reg <= m_ys;
            p_xs_reg <= m_xs;
            p_yc_reg <= m_yc;
        end
        if (adv3)
        begin
            hit3_reg <= hit3_next;
            tx3_reg  <= u_val[15:8];
            ty3_reg  <= v_val[15:8];
        end
        if (adv4)
        begin
            hit4_reg  <= hit3_reg;
            addr4_reg <= addr_next;
        end
    end

endmodule

// File: rtl/rotozoom_texel_mapper_unit.sv
// pipeline: four register stages; a result moves from stage 1 to stage 4, whose register drives the output
// throughput: one request per cycle while m_tready is high and the trig unit is idle
// after any register write the input stalls while the trig unit recomputes,
// with a zoom divide added when zoom is not 256 or 0
// reset: registers take their reset values, the pipeline empties, trig is cos 256, sin 0
// depends on rzm_pkg, rzm_cfg_regs, rzm_trig_unit, rzm_map_pipe
`timescale 1ns / 1ps

module rotozoom_texel_mapper_unit #(
    parameter int ANGLE_STEPS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rzm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rzm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rzm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // pixel_x[9:0], pixel_y[19:10], zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // texel_address[15:0]
    output logic [0:0]                     m_tuser    // hit[0]
);

    rzm_pkg::rzm_cfg_t  cfg;
    rzm_pkg::rzm_trig_t trig;
    logic               cfg_write;
    logic               trig_busy;

    // configuration registers
    rzm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .cfg_write (cfg_write)
    );

    // cosine and sine scaled by zoom
    rzm_trig_unit #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg       (cfg),
        .busy      (trig_busy),
        .trig      (trig)
    );

    // per-pixel mapping pipeline
    rzm_map_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .trig          (trig),
        .hold          (trig_busy),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .pixel_x       (s_tdata[9:0]),
        .pixel_y       (s_tdata[19:10]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .hit           (m_tuser[0]),
        .texel_address (m_tdata)
    );

endmodule
